>>> hdl/skpi_pkg.sv
// ============================================================================
// skpi_pkg: shared types and constants of the sorted key position index
// Sizes of the key table and position lists, status and kind codes.
// ============================================================================
package skpi_pkg;

  localparam int unsigned MaxKeys      = 64;
  localparam int unsigned MaxPositions = 8;
  localparam int unsigned KeyBits      = 32;
  localparam int unsigned RankW        = $clog2(MaxKeys);
  localparam int unsigned CountW       = $clog2(MaxKeys + 1);
  localparam int unsigned PosIdxW      = $clog2(MaxPositions);
  localparam int unsigned LenW         = $clog2(MaxPositions + 1);
  localparam int unsigned StoreAw      = RankW + PosIdxW;

  typedef enum logic [1:0] {
    KIND_PUT     = 2'd0,
    KIND_GET_KEY = 2'd1,
    KIND_GET_RANK = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_TFULL    = 3'd3,
    ST_LFULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic signed [31:0] key;
    logic signed [31:0] position;
    logic [5:0]  rank;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic signed [31:0] found_key;
    logic [6:0]  unique_keys;
    logic [3:0]  position_count;
    logic [30:0] position_out;
    logic        last;
  } rsp_t;

endpackage

>>> hdl/skpi_if.sv
// ============================================================================
// skpi_if: valid/ready channel
// Carries one beat of a request or a result with valid and ready.
// ============================================================================
interface skpi_req_if;
  import skpi_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface skpi_rsp_if;
  import skpi_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sorted_key_position_index.sv
// ============================================================================
// sorted_key_position_index: sorted key table with position lists
// Binary search, shifted insert and streamed position lists.
// ============================================================================
// One request is taken at a time; ready is low until its last result beat
// has been taken. A lookup spends a read and a compare state (S_PROBE,
// S_CMP) on each binary search probe, fed from the key memory, which has
// a single registered read port. The search ends with one more probe round
// once the bounds meet, so it takes up to eight rounds for 64 keys. An
// insert of a new key then moves the later entries up one rank, with a read
// and a write state per entry (S_SHRD, S_SHWR); a get streams one result
// beat at a time after its search, fetching the next position only once the
// last beat has been taken. The stores start empty after reset with no
// clearing pass; only their key count and next free list slot are reset.
module sorted_key_position_index import skpi_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  skpi_req_if.sink   req,
  skpi_rsp_if.source rsp
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PROBE  = 10'b0000000010,
    S_CMP    = 10'b0000000100,
    S_HIT    = 10'b0000001000,
    S_SHRD   = 10'b0000010000,
    S_SHWR   = 10'b0000100000,
    S_INS    = 10'b0001000000,
    S_LRD    = 10'b0010000000,
    S_STREAM = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [KeyBits-1:0] keys_mem [MaxKeys];
  logic [RankW-1:0]   slot_mem [MaxKeys];
  logic [LenW-1:0]    len_mem  [MaxKeys];
  logic [30:0]        pos_mem  [MaxKeys*MaxPositions];

  req_t              req_q;
  logic [CountW-1:0] count_q, free_q, lo_q, hi_q, idx_q;
  logic signed [KeyBits-1:0] rkey_q;
  logic [RankW-1:0]  rslot_q;
  logic [LenW-1:0]   rlen_q, pi_q;
  logic [30:0]       rpos_q;
  rsp_t              out_q;
  logic              outv_q;
  logic [2:0]        out_code;
  logic              hit;

  logic [CountW-1:0] mid;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Memory reads are registered; addresses come from the sequencer.
  // Outside the shift and insert states, the read port stays on entry lo once the search has ended.
  logic [RankW-1:0] kaddr;
  always_comb begin
    kaddr = mid[RankW-1:0];
    if (state_q == S_SHRD) kaddr = RankW'(idx_q - 1'b1);
    if (state_q == S_HIT || state_q == S_CMP || state_q == S_LRD ||
        state_q == S_STREAM || state_q == S_OUT) kaddr = lo_q[RankW-1:0];
  end

  always_ff @(posedge clk_i) begin
    rkey_q  <= keys_mem[kaddr];
    rslot_q <= slot_mem[kaddr];
    rlen_q  <= len_mem[rslot_q];
    rpos_q  <= pos_mem[{rslot_q, pi_q[PosIdxW-1:0]}];
    if (state_q == S_SHWR) begin
      keys_mem[idx_q[RankW-1:0]] <= rkey_q;
      slot_mem[idx_q[RankW-1:0]] <= rslot_q;
    end
    if (state_q == S_INS) begin
      keys_mem[lo_q[RankW-1:0]] <= req_q.key;
      slot_mem[lo_q[RankW-1:0]] <= free_q[RankW-1:0];
      len_mem[free_q[RankW-1:0]] <= LenW'(1);
      pos_mem[{free_q[RankW-1:0], PosIdxW'(0)}] <= req_q.position[30:0];
    end
    if (state_q == S_LRD && req_q.kind == KIND_PUT && rlen_q < LenW'(MaxPositions)) begin
      len_mem[rslot_q] <= rlen_q + 1'b1;
      pos_mem[{rslot_q, rlen_q[PosIdxW-1:0]}] <= req_q.position[30:0];
    end
  end

  logic probe_wait_q;
  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = outv_q;
  assign rsp.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      free_q  <= '0;
      outv_q  <= 1'b0;
      lo_q <= '0; hi_q <= '0; idx_q <= '0; pi_q <= '0;
      probe_wait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp.valid && rsp.ready) outv_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req.valid) begin
          req_q <= req.data;
          lo_q <= (req.data.kind == KIND_GET_RANK) ? CountW'(req.data.rank) : '0;
          hi_q <= count_q; pi_q <= '0;
          probe_wait_q <= 1'b0;
        end
        S_PROBE: ;
        S_CMP: if (lo_q < hi_q) begin
          // rkey_q holds keys_mem[mid] read in S_PROBE.
          if (rkey_q < req_q.key) lo_q <= mid + 1'b1;
          else hi_q <= mid;
        end
        S_HIT: begin
          idx_q <= count_q;
          pi_q <= '0;
        end
        S_SHRD: ;
        S_SHWR: idx_q <= idx_q - 1'b1;
        S_INS: begin
          count_q <= count_q + 1'b1;
          free_q  <= free_q + 1'b1;
          out_q <= '{ST_OK, '0, count_q + 1'b1, '0, '0, 1'b1};
          outv_q <= 1'b1;
        end
        S_LRD: begin
          probe_wait_q <= ~probe_wait_q;
          if (probe_wait_q && req_q.kind == KIND_PUT) begin
            out_q <= '{(rlen_q >= LenW'(MaxPositions)) ? ST_LFULL : ST_OK,
                       '0, count_q, '0, '0, 1'b1};
            outv_q <= 1'b1;
          end
        end
        S_STREAM: begin
          probe_wait_q <= ~probe_wait_q;
          if (probe_wait_q) begin
            out_q <= '{ST_OK, rkey_q, count_q, rlen_q, rpos_q,
                       (pi_q + 1'b1 == rlen_q)};
            outv_q <= 1'b1;
            pi_q <= pi_q + 1'b1;
          end
        end
        S_OUT: ;
        default: ;
      endcase
      if (state_d == S_OUT && state_q != S_OUT && state_q != S_INS &&
          state_q != S_LRD && state_q != S_STREAM) begin
        out_q <= '{status_e'(out_code), '0, count_q, '0, '0, 1'b1};
        outv_q <= 1'b1;
      end
    end
  end

  assign hit = (lo_q < count_q) && (rkey_q == req_q.key);

  always_comb begin
    state_d  = state_q;
    out_code = ST_NOTFOUND;
    unique case (state_q)
      S_IDLE: if (req.valid) begin
        if (req.data.kind == KIND_PUT && req.data.position[31]) begin
          state_d = S_OUT; out_code = ST_BADPOS;
        end else if (req.data.kind == KIND_GET_RANK) begin
          if (CountW'(req.data.rank) < count_q) state_d = S_HIT;
          else state_d = S_OUT;
        end else if (req.data.kind == KIND_UNUSED) begin
          state_d = S_OUT;
        end else state_d = S_PROBE;
      end
      S_PROBE: state_d = S_CMP;
      S_CMP: if (!(lo_q < hi_q)) state_d = S_HIT;
             else state_d = S_PROBE;
      S_HIT: begin
        // rkey_q and rslot_q hold entry lo after a search; on a get by rank they hold it only from S_LRD on.
        if (req_q.kind == KIND_GET_RANK) state_d = S_LRD;
        else if (hit) state_d = S_LRD;
        else if (req_q.kind == KIND_PUT) begin
          if (count_q >= CountW'(MaxKeys) || free_q >= CountW'(MaxKeys)) begin
            state_d = S_OUT; out_code = ST_TFULL;
          end else if (count_q > lo_q) state_d = S_SHRD;
          else state_d = S_INS;
        end else state_d = S_OUT;
      end
      S_SHRD: state_d = S_SHWR;
      S_SHWR: state_d = (idx_q - 1'b1 > lo_q) ? S_SHRD : S_INS;
      S_INS: state_d = S_OUT;
      S_LRD: if (probe_wait_q) begin
        if (req_q.kind == KIND_PUT) state_d = S_OUT;
        else if (rlen_q == '0) begin
          state_d = S_OUT;
        end else state_d = S_STREAM;
      end
      S_STREAM: if (probe_wait_q) state_d = S_OUT;
      S_OUT: if (!outv_q || rsp.ready) begin
        if (req_q.kind != KIND_PUT && pi_q != '0 && pi_q < rlen_q)
          state_d = S_STREAM;
        else state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/skpi_checker.sv
// ============================================================================
// skpi_checker: port level checks of the sorted key position index
// Watches the request and result channels and the beat sequence.
// ============================================================================
module skpi_checker import skpi_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // A result beat never shows while a new request is being taken.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |-> !rsp_valid) else $error("overlap");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data))) else $error("hold");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_data.status <= 3'd4)) else $error("status");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_data.unique_keys <= 7'(MaxKeys))) else $error("count");

endmodule

bind sorted_key_position_index skpi_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
